/* rtl/gfba_pkg.sv */
// Shared types, codes and the microcode table for the grouped free-block allocator.
// No dependencies; used by gfba_seq, grouped_free_block_allocator and the testbench.
package gfba_pkg;

  localparam int GROUP_SIZE_DEF = 32;
  localparam int BLK_W          = 24;

  // request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_FILL  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_ALLOC   = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_SPILL   = 2'd2;
  localparam logic [1:0] STAT_BUSY    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_ALLOC      = 4'd1,
    ST_NOSPACE    = 4'd2,
    ST_BUSY       = 4'd3,
    ST_PUSH       = 4'd4,
    ST_FILL       = 4'd5,
    ST_SPILL_HEAD = 4'd6,
    ST_SPILL_LOOP = 4'd7,
    ST_RESTART    = 4'd8
  } step_t;

  typedef enum logic [3:0] {
    OPC_IDLE, OPC_POP, OPC_NOSPACE, OPC_BUSY, OPC_PUSH, OPC_FILL,
    OPC_SPILL_HEAD, OPC_SPILL_WORD, OPC_RESTART
  } op_t;

  // read address source for the stack RAM
  typedef enum logic [1:0] {
    ADDR_TOP, ADDR_IDX, ADDR_NEXT
  } addr_sel_t;

  // sequencing: next step, jump to target, dispatch on request, loop until done
  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_GOTO, SEQ_DISPATCH, SEQ_LOOP
  } seq_t;

  typedef struct packed {
    op_t       op;
    addr_sel_t addr_sel;
    seq_t      seq;
    step_t     target;
  } ctrl_t;

  typedef struct packed {
    step_t dispatch;
    logic  loop_done;
  } seq_in_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    unique case (s)
      ST_IDLE:       c = '{OPC_IDLE,       ADDR_TOP,  SEQ_DISPATCH, ST_IDLE};
      ST_ALLOC:      c = '{OPC_POP,        ADDR_TOP,  SEQ_GOTO,     ST_IDLE};
      ST_NOSPACE:    c = '{OPC_NOSPACE,    ADDR_TOP,  SEQ_GOTO,     ST_IDLE};
      ST_BUSY:       c = '{OPC_BUSY,       ADDR_TOP,  SEQ_GOTO,     ST_IDLE};
      ST_PUSH:       c = '{OPC_PUSH,       ADDR_TOP,  SEQ_GOTO,     ST_IDLE};
      ST_FILL:       c = '{OPC_FILL,       ADDR_TOP,  SEQ_GOTO,     ST_IDLE};
      ST_SPILL_HEAD: c = '{OPC_SPILL_HEAD, ADDR_IDX,  SEQ_NEXT,     ST_IDLE};
      ST_SPILL_LOOP: c = '{OPC_SPILL_WORD, ADDR_NEXT, SEQ_LOOP,     ST_RESTART};
      ST_RESTART:    c = '{OPC_RESTART,    ADDR_TOP,  SEQ_GOTO,     ST_IDLE};
      default:       c = '{OPC_IDLE,       ADDR_TOP,  SEQ_GOTO,     ST_IDLE};
    endcase
    return c;
  endfunction

endpackage

/* rtl/gfba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gfba_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/gfba_seq.sv */
// Microcode sequencer: step counter, control-word table and jump logic.
// Depends on gfba_pkg (step_t, ctrl_t, seq_in_t, ucode).
module gfba_seq (
  input  logic              clk,
  input  logic              rst,
  input  gfba_pkg::seq_in_t seq_in,
  output gfba_pkg::ctrl_t   ctrl,
  output logic              busy
);
  import gfba_pkg::*;

  step_t step;
  step_t step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    unique case (ctrl.seq)
      SEQ_NEXT:     step_next = step_t'(step + 4'd1);
      SEQ_GOTO:     step_next = ctrl.target;
      SEQ_DISPATCH: step_next = seq_in.dispatch;
      SEQ_LOOP:     step_next = seq_in.loop_done ? ctrl.target : step;
      default:      step_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = ucode(step);
    busy = (step != ST_IDLE);
  end

endmodule

/* rtl/grouped_free_block_allocator.sv */
// Grouped free-block allocator: on-chip stack of free block numbers with refill and spill.
// Depends on gfba_pkg, gfba_seq and gfba_ram.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------------
//   request  | start, busy             | req_type, block_number, fill_word
//   result   | strobe (one cycle/beat) | status, alloc_block, refill_request,
//            |                         | spill_block, spill_word, last
//
// Alloc, plain free, refill word while refilling and busy reply: accept, one action step.
// Alloc and busy reply give a result beat, registered, in the cycle after the action step.
// A refill word while not refilling or an unused request type ends at the accept step.
// Free on a full stack: spill head, spill loop walking the stack RAM one entry per cycle,
// then restart; a beat goes out on each spill head and loop step, back to back.
// Synchronous reset empties the stack and returns the sequencer to idle; no clearing pass.
// Result beats cannot be held off; busy stays high until the item's last step is done.
module grouped_free_block_allocator #(
  parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type,
  input  logic [gfba_pkg::BLK_W-1:0] block_number,
  input  logic [gfba_pkg::BLK_W-1:0] fill_word,
  output logic                       strobe,
  output logic [1:0]                 status,
  output logic [gfba_pkg::BLK_W-1:0] alloc_block,
  output logic                       refill_request,
  output logic [gfba_pkg::BLK_W-1:0] spill_block,
  output logic [gfba_pkg::BLK_W-1:0] spill_word,
  output logic                       last
);
  import gfba_pkg::*;

  localparam int CW = $clog2(GROUP_SIZE + 1);
  localparam int IW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
  localparam logic [CW-1:0]    G_CNT  = CW'(GROUP_SIZE);
  localparam logic [IW-1:0]    G_LAST = IW'(GROUP_SIZE - 1);
  localparam logic [BLK_W-1:0] G_WORD = BLK_W'(GROUP_SIZE);

  ctrl_t   ctrl;
  seq_in_t seq_in;
  logic    accept;

  // architectural state; stack entries below count are always written before use
  logic [CW-1:0] count, count_next;
  logic          refilling, refilling_next;
  logic [CW-1:0] fill_pos, fill_pos_next;
  logic [IW-1:0] idx, idx_next;

  logic [BLK_W-1:0] blk_r, word_r;

  logic             wr_en;
  logic [IW-1:0]    wr_addr, rd_addr;
  logic [BLK_W-1:0] wr_data, rd_data;

  logic [CW-1:0] count_m1;
  logic [CW-1:0] fill_cnt;
  logic          loop_done;

  logic             strobe_next, refill_next, last_next;
  logic [1:0]       status_next;
  logic [BLK_W-1:0] alloc_next, sblk_next, sword_next;

  gfba_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .seq_in (seq_in),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  gfba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (GROUP_SIZE)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept    = start && !busy;
  assign count_m1  = count - CW'(1);
  assign loop_done = (idx == G_LAST);
  assign fill_cnt  = (word_r > G_WORD) ? G_CNT : word_r[CW-1:0];

  // dispatch straight from the request ports while idle
  always_comb begin
    seq_in.loop_done = loop_done;
    seq_in.dispatch  = ST_IDLE;
    if (start) begin
      if (req_type == REQ_FILL) begin
        seq_in.dispatch = refilling ? ST_FILL : ST_IDLE;
      end else if (req_type == REQ_ALLOC || req_type == REQ_FREE) begin
        if (refilling) begin
          seq_in.dispatch = ST_BUSY;
        end else if (req_type == REQ_ALLOC) begin
          seq_in.dispatch = (count == '0) ? ST_NOSPACE : ST_ALLOC;
        end else begin
          seq_in.dispatch = (count >= G_CNT) ? ST_SPILL_HEAD : ST_PUSH;
        end
      end
    end
  end

  // read address: top of stack is fetched during idle so the pop step has it
  always_comb begin
    case (ctrl.addr_sel)
      ADDR_TOP:  rd_addr = (count == '0) ? '0 : count_m1[IW-1:0];
      ADDR_IDX:  rd_addr = idx;
      ADDR_NEXT: rd_addr = loop_done ? idx : idx + IW'(1);
      default:   rd_addr = idx;
    endcase
  end

  always_comb begin
    count_next     = count;
    refilling_next = refilling;
    fill_pos_next  = fill_pos;
    idx_next       = idx;
    wr_en          = 1'b0;
    wr_addr        = count[IW-1:0];
    wr_data        = blk_r;
    strobe_next    = 1'b0;
    status_next    = STAT_ALLOC;
    alloc_next     = '0;
    refill_next    = 1'b0;
    sblk_next      = '0;
    sword_next     = '0;
    last_next      = 1'b0;
    case (ctrl.op)
      OPC_IDLE: begin
        idx_next = '0;
      end
      OPC_POP: begin
        strobe_next = 1'b1;
        last_next   = 1'b1;
        if (rd_data == '0) begin
          // end-of-list mark
          status_next = STAT_NOSPACE;
          count_next  = '0;
        end else begin
          alloc_next = rd_data;
          count_next = count_m1;
          if (count_m1 == '0) begin
            refill_next    = 1'b1;
            refilling_next = 1'b1;
            fill_pos_next  = '0;
          end
        end
      end
      OPC_NOSPACE: begin
        strobe_next = 1'b1;
        last_next   = 1'b1;
        status_next = STAT_NOSPACE;
        count_next  = '0;
      end
      OPC_BUSY: begin
        strobe_next = 1'b1;
        last_next   = 1'b1;
        status_next = STAT_BUSY;
      end
      OPC_PUSH: begin
        wr_en      = 1'b1;
        count_next = count + CW'(1);
      end
      OPC_FILL: begin
        if (fill_pos == '0) begin
          count_next = fill_cnt;
        end else begin
          wr_en   = 1'b1;
          wr_addr = IW'(fill_pos - CW'(1));
          wr_data = word_r;
        end
        if (fill_pos == G_CNT) begin
          refilling_next = 1'b0;
          fill_pos_next  = '0;
        end else begin
          fill_pos_next = fill_pos + CW'(1);
        end
      end
      OPC_SPILL_HEAD: begin
        strobe_next = 1'b1;
        status_next = STAT_SPILL;
        sblk_next   = blk_r;
        sword_next  = G_WORD;
      end
      OPC_SPILL_WORD: begin
        strobe_next = 1'b1;
        status_next = STAT_SPILL;
        sblk_next   = blk_r;
        sword_next  = rd_data;
        last_next   = loop_done;
        idx_next    = idx + IW'(1);
      end
      OPC_RESTART: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        count_next = CW'(1);
      end
      default: begin
        idx_next = idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      refilling <= 1'b0;
      fill_pos  <= '0;
      idx       <= '0;
      strobe    <= 1'b0;
    end else begin
      count     <= count_next;
      refilling <= refilling_next;
      fill_pos  <= fill_pos_next;
      idx       <= idx_next;
      strobe    <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_r  <= block_number;
      word_r <= fill_word;
    end
    status         <= status_next;
    alloc_block    <= alloc_next;
    refill_request <= refill_next;
    spill_block    <= sblk_next;
    spill_word     <= sword_next;
    last           <= last_next;
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for grouped_free_block_allocator: queued requests, result monitor,
// and a free-list predictor of the result beats. Depends on gfba_pkg and the allocator RTL.
module testbench;
  import gfba_pkg::*;

  localparam int GS = GROUP_SIZE_DEF;
  localparam int BW = BLK_W;
  localparam int ITEMS = 360;
  localparam int QUIET_TAIL = 50;
  localparam int LIMIT_CYCLES = 200000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [GS-1:0][BW-1:0] stack;
    logic [5:0]            count;
    logic                  refilling;
    logic [5:0]            fill_pos;
  } free_list_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [BW-1:0] alloc_block;
    logic          refill_req;
    logic [BW-1:0] spill_blk;
    logic [BW-1:0] spill_wd;
    logic          is_last;
  } beat_t;

  typedef struct {
    logic [1:0]    req;
    logic [BW-1:0] blk;
    logic [BW-1:0] word;
    int            gap;
  } request_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [1:0]    req_type = REQ_ALLOC;
  logic [BW-1:0] block_number = '0;
  logic [BW-1:0] fill_word = '0;
  logic          strobe;
  logic [1:0]    status;
  logic [BW-1:0] alloc_block;
  logic          refill_request;
  logic [BW-1:0] spill_block;
  logic [BW-1:0] spill_word;
  logic          last;

  request_t   pending_reqs[$];
  beat_t      expected_beats[$];
  beat_t      scratch_beats[$];
  free_list_t tracked_list = '0;
  free_list_t planned_list = '0;
  int         issued_cnt = 0;
  int         accepted_cnt = 0;
  int         fail_count = 0;
  int         cycle_cnt = 0;
  int         effective_items = 0;
  bit         idle_on = 1'b1;

  grouped_free_block_allocator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .block_number(block_number),
    .fill_word(fill_word),
    .strobe(strobe),
    .status(status),
    .alloc_block(alloc_block),
    .refill_request(refill_request),
    .spill_block(spill_block),
    .spill_word(spill_word),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one request to a free list and appends the beats it produces.
  function automatic void step_free_list(ref free_list_t st, input logic [1:0] req,
                                         input logic [BW-1:0] blk, input logic [BW-1:0] word,
                                         ref beat_t beats[$]);
    beat_t         b;
    logic [BW-1:0] popped;
    b = '0;
    b.is_last = 1'b1;
    case (req)
      REQ_FILL: begin
        if (st.refilling) begin
          // first word is the group count, clamped to the group size
          if (st.fill_pos == 0) st.count = (word > GS) ? 6'(GS) : word[5:0];
          else st.stack[st.fill_pos - 1] = word;
          st.fill_pos = 6'(st.fill_pos + 1);
          if (st.fill_pos > GS) begin
            st.refilling = 1'b0;
            st.fill_pos = '0;
          end
        end
      end
      REQ_ALLOC, REQ_FREE: begin
        if (st.refilling) begin
          b.status = STAT_BUSY;
          beats.push_back(b);
        end else if (req == REQ_ALLOC) begin
          if (st.count == 0) begin
            b.status = STAT_NOSPACE;
            beats.push_back(b);
          end else begin
            st.count = 6'(st.count - 1);
            popped = st.stack[st.count];
            if (popped == '0) begin
              // end-of-chain mark: report no space and drop the group
              st.count = '0;
              b.status = STAT_NOSPACE;
            end else begin
              b.status = STAT_ALLOC;
              b.alloc_block = popped;
              b.refill_req = (st.count == 0);
              if (st.count == 0) begin
                st.refilling = 1'b1;
                st.fill_pos = '0;
              end
            end
            beats.push_back(b);
          end
        end else begin
          if (st.count >= GS) begin
            b.status = STAT_SPILL;
            b.spill_blk = blk;
            b.spill_wd = BW'(GS);
            b.is_last = 1'b0;
            beats.push_back(b);
            for (int i = 0; i < GS; i++) begin
              b.spill_wd = st.stack[i];
              b.is_last = (i == GS - 1);
              beats.push_back(b);
            end
            st.count = '0;
          end
          st.stack[st.count] = blk;
          st.count = 6'(st.count + 1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [BW-1:0] random_block();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return BW'($urandom);
    endcase
  endfunction

  function automatic logic [BW-1:0] random_group_count();
    case ($urandom_range(0, 5))
      0: return BW'(GS);
      1: return BW'($urandom_range(GS + 1, 24'hFFFFFF));
      2: return '0;
      3: return '1;
      default: return BW'($urandom_range(1, GS - 1));
    endcase
  endfunction

  // Queues one request; tracks the planned list so the stream can follow the block's state.
  function automatic void add_request(logic [1:0] req, logic [BW-1:0] blk,
                                      logic [BW-1:0] word);
    request_t r;
    r.req = req;
    r.blk = blk;
    r.word = word;
    r.gap = 0;
    if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
    if (idle_on && effective_items < ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0)
      r.gap = $urandom_range(1, 5);
    if (!(req == REQ_UNUSED || (req == REQ_FILL && !planned_list.refilling)))
      effective_items++;
    step_free_list(planned_list, req, blk, word, scratch_beats);
    scratch_beats.delete();
    pending_reqs.push_back(r);
  endfunction

  task automatic check_field(string name, logic [BW-1:0] want, logic [BW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // driver: one request per accept, optional gap before a request
  always @(negedge clk) begin : drive
    request_t cur;
    int       gap_left;
    bit       gap_served;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
      gap_served = 1'b0;
    end else if (issued_cnt == accepted_cnt) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        start <= 1'b0;
      end else if (pending_reqs[0].gap > 0 && !gap_served) begin
        gap_left = pending_reqs[0].gap - 1;
        gap_served = 1'b1;
        start <= 1'b0;
      end else begin
        cur = pending_reqs.pop_front();
        gap_served = 1'b0;
        req_type <= cur.req;
        block_number <= cur.blk;
        fill_word <= cur.word;
        start <= 1'b1;
        issued_cnt++;
      end
    end
  end

  // monitor: check result beats, predict on accepted requests
  always @(posedge clk) begin : monitor
    beat_t want;
    if (!rst) begin
      if (strobe) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          check_field("status", BW'(want.status), BW'(status));
          check_field("alloc_block", want.alloc_block, alloc_block);
          check_field("refill_request", BW'(want.refill_req), BW'(refill_request));
          check_field("spill_block", want.spill_blk, spill_block);
          check_field("spill_word", want.spill_wd, spill_word);
          check_field("last", BW'(want.is_last), BW'(last));
        end
      end
      if (start && !busy) begin
        step_free_list(tracked_list, req_type, block_number, fill_word, expected_beats);
        accepted_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL grouped_free_block_allocator");
      $finish;
    end
  end

  initial begin : stimulus
    int roll;
    int burst_left;
    bit free_heavy;
    burst_left = 0;
    free_heavy = 1'b0;

    // directed: empty stack, ignored requests, zero end mark, refill request, busy replies
    add_request(REQ_ALLOC, '0, '0);
    add_request(REQ_FILL, '0, '1);
    add_request(REQ_UNUSED, '1, '1);
    add_request(REQ_FREE, '1, '0);
    add_request(REQ_FREE, '0, '1);
    add_request(REQ_FREE, 24'h000001, '0);
    add_request(REQ_ALLOC, '1, '1);
    add_request(REQ_ALLOC, '0, '0);
    add_request(REQ_ALLOC, '0, '0);
    add_request(REQ_FREE, 24'h800000, '0);
    add_request(REQ_ALLOC, '0, '0);
    add_request(REQ_ALLOC, '0, '0);
    add_request(REQ_FREE, 24'h5A5A5A, 24'hA5A5A5);
    add_request(REQ_UNUSED, 24'hA5A5A5, 24'h5A5A5A);

    // random: mostly complete refills and alloc/free bursts, some noise
    while (effective_items < ITEMS) begin
      roll = $urandom_range(0, 19);
      if (planned_list.refilling) begin
        if (roll == 0) add_request(REQ_ALLOC, random_block(), random_block());
        else if (roll == 1) add_request(REQ_FREE, random_block(), random_block());
        else if (planned_list.fill_pos == 0)
          add_request(REQ_FILL, random_block(), random_group_count());
        else add_request(REQ_FILL, random_block(), random_block());
      end else begin
        if (burst_left == 0) begin
          free_heavy = 1'($urandom_range(0, 1));
          burst_left = $urandom_range(4, 24);
        end
        burst_left--;
        if (roll == 0) add_request(REQ_FILL, random_block(), random_block());
        else if (roll == 1) add_request(REQ_UNUSED, random_block(), random_block());
        else if ((roll < 15) == free_heavy)
          add_request(REQ_FREE, random_block(), random_block());
        else add_request(REQ_ALLOC, random_block(), random_block());
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_reqs.size() != 0 || accepted_cnt != issued_cnt) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (GS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS grouped_free_block_allocator");
    end else begin
      $display("FAIL grouped_free_block_allocator");
    end
    $finish;
  end

endmodule
